### design/fbpa_pkg.sv
package fbpa_pkg;

  localparam int unsigned CapacityDef = 1024;

  localparam int unsigned DataW   = 32;
  localparam int unsigned SizeW   = 17;
  localparam int unsigned CountW  = 11;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned RemW    = SizeW;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [SizeW-1:0]  SizeMax       = 17'h10000;
  localparam logic [DataW-1:0]  PoolBaseRst   = 32'd0;
  localparam logic [SizeW-1:0]  BlockBytesRst = 17'd16;
  localparam logic [CountW-1:0] BlockCountRst = 11'd1024;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_RANGE     = 3'd3,
    ST_DOUBLE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_BLOCK_BYTES = 2'd1,
    REG_BLOCK_COUNT = 2'd2
  } reg_e;

endpackage

### design/fbpa_ram.sv
module fbpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/fixed_block_pool_allocator_top.sv
// fixed-size block pool allocator with a lifo free list
// command channel: an item (kind_i, address_i) is taken at a clock edge with
//   start high and busy low; busy stays high while the item is worked on
// result channel: result_valid_o is high for exactly one cycle with status_o,
//   blk_addr_o and free_blocks_o; the receiver cannot stall it
// config: apb write of pool base (0x0), block size (0x4), block count (0x8),
//   only while the block is idle (a rule for the user, not enforced); pready is tied high
// steps from accept to result strobe:
//   allocate from the free list  next link read, multiply, add
//   allocate an untouched block  multiply, add
//   empty pool, restart, unused  answered from idle with no further step
//   release                      the 32-step remainder divider, the range check,
//     then, if the checks pass, the allocated flag read and write back
// one item is in work at a time; the next start is taken in the cycle the
//   result strobe is shown
// reset: registers return to base 0, size 16, count 1024, the pool is all free;
//   link and flag memories are not cleared and are only read where written
module fixed_block_pool_allocator_top import fbpa_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [KindW-1:0]   kind_i,
  input  logic [DataW-1:0]   address_i,
  output logic               result_valid_o,
  output logic [StatusW-1:0] status_o,
  output logic [DataW-1:0]   blk_addr_o,
  output logic [CountW-1:0]  free_blocks_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned XW = (IW > CountW) ? IW : CountW;
  localparam int unsigned PW = IW + SizeW;
  localparam logic [IW-1:0] CapIdx = IW'(CAPACITY);
  localparam logic [CountW-1:0] FreeRst =
    (CAPACITY < 32'(BlockCountRst)) ? CountW'(CAPACITY) : BlockCountRst;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POP  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_ADD  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_FLAG = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [DataW-1:0]  pool_base_q;
  logic [SizeW-1:0]  block_bytes_q;
  logic [CountW-1:0] block_count_q;

  logic [IW-1:0]     head_q, head_d;
  logic [IW-1:0]     untouched_q, untouched_d;
  logic [CountW-1:0] free_q, free_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic [DataW-1:0]  quo_q, quo_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  logic              res_valid_q, res_valid_d;
  status_e           res_status_q, res_status_d;
  logic [DataW-1:0]  res_addr_q, res_addr_d;
  logic [CountW-1:0] res_free_q, res_free_d;

  logic [SizeW-1:0]  eff_size;
  logic [XW-1:0]     count_x;
  logic [IW-1:0]     eff_count;
  logic [CountW-1:0] free_dec;
  logic [DataW-1:0]  diff;
  logic [RemW:0]     rem_sh;
  logic [RemW:0]     rem_sub;

  logic              link_we;
  logic [IW-1:0]     link_rdata;
  logic              flag_we;
  logic [AW-1:0]     flag_waddr;
  logic [0:0]        flag_wdata;
  logic [0:0]        flag_rdata;

  // apb register file
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= PoolBaseRst;
      block_bytes_q <= BlockBytesRst;
      block_count_q <= BlockCountRst;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_POOL_BASE:   pool_base_q   <= pwdata;
        REG_BLOCK_BYTES: block_bytes_q <= pwdata[SizeW-1:0];
        REG_BLOCK_COUNT: block_count_q <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POOL_BASE:   prdata = pool_base_q;
      REG_BLOCK_BYTES: prdata = DataW'(block_bytes_q);
      REG_BLOCK_COUNT: prdata = DataW'(block_count_q);
      default:         prdata = '0;
    endcase
  end

  // clamped configuration
  always_comb begin
    if (block_bytes_q == '0) begin
      eff_size = SizeW'(1);
    end else if (block_bytes_q > SizeMax) begin
      eff_size = SizeMax;
    end else begin
      eff_size = block_bytes_q;
    end
  end

  always_comb begin
    if (block_count_q == '0) begin
      count_x = XW'(1);
    end else if (XW'(block_count_q) > XW'(CAPACITY)) begin
      count_x = XW'(CAPACITY);
    end else begin
      count_x = XW'(block_count_q);
    end
  end

  assign eff_count = count_x[IW-1:0];
  assign free_dec  = (free_q != '0) ? free_q - CountW'(1) : free_q;
  assign diff      = address_i - pool_base_q;

  // one restoring divide step
  assign rem_sh  = {rem_q, quo_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, eff_size};

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    untouched_d  = untouched_q;
    free_d       = free_q;
    idx_d        = idx_q;
    prod_d       = prod_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    neg_d        = neg_q;
    cnt_d        = cnt_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_free_d   = res_free_q;
    link_we      = 1'b0;
    flag_we      = 1'b0;
    flag_waddr   = untouched_q[AW-1:0];
    flag_wdata   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (kind_i)
            KIND_ALLOC: begin
              if (head_q < CapIdx) begin
                state_d = S_POP;
              end else if (untouched_q < eff_count) begin
                idx_d       = untouched_q;
                untouched_d = untouched_q + IW'(1);
                flag_we     = 1'b1;
                flag_waddr  = untouched_q[AW-1:0];
                free_d      = free_dec;
                state_d     = S_MUL;
              end else begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
                res_addr_d   = '0;
                res_free_d   = free_q;
              end
            end
            KIND_RELEASE: begin
              neg_d   = diff[DataW-1];
              quo_d   = diff[DataW-1] ? (DataW'(0) - diff) : diff;
              rem_d   = '0;
              cnt_d   = '0;
              state_d = S_DIV;
            end
            KIND_RESTART: begin
              head_d       = CapIdx;
              untouched_d  = '0;
              free_d       = CountW'(eff_count);
              res_valid_d  = 1'b1;
              res_status_d = ST_OK;
              res_addr_d   = '0;
              res_free_d   = CountW'(eff_count);
            end
            default: begin
              res_valid_d  = 1'b1;
              res_status_d = ST_OK;
              res_addr_d   = '0;
              res_free_d   = free_q;
            end
          endcase
        end
      end
      S_POP: begin
        idx_d      = head_q;
        head_d     = (link_rdata > CapIdx) ? CapIdx : link_rdata;
        flag_we    = 1'b1;
        flag_waddr = head_q[AW-1:0];
        free_d     = free_dec;
        state_d    = S_MUL;
      end
      S_MUL: begin
        prod_d  = PW'(idx_q) * PW'(eff_size);
        state_d = S_ADD;
      end
      S_ADD: begin
        res_valid_d  = 1'b1;
        res_status_d = ST_OK;
        res_addr_d   = pool_base_q + DataW'(prod_q);
        res_free_d   = free_q;
        state_d      = S_IDLE;
      end
      S_DIV: begin
        if (!rem_sub[RemW]) begin
          rem_d = rem_sub[RemW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[RemW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b0};
        end
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        res_addr_d = '0;
        res_free_d = free_q;
        state_d    = S_IDLE;
        if (rem_q != '0) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_UNALIGNED;
        end else if (neg_q || (quo_q >= DataW'(eff_count))) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_RANGE;
        end else if (quo_q >= DataW'(untouched_q)) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_DOUBLE;
        end else begin
          idx_d   = quo_q[IW-1:0];
          state_d = S_FLAG;
        end
      end
      S_FLAG: begin
        res_valid_d = 1'b1;
        res_addr_d  = '0;
        state_d     = S_IDLE;
        if (flag_rdata == 1'b0) begin
          res_status_d = ST_DOUBLE;
          res_free_d   = free_q;
        end else begin
          flag_we      = 1'b1;
          flag_waddr   = idx_q[AW-1:0];
          flag_wdata   = 1'b0;
          link_we      = 1'b1;
          head_d       = idx_q;
          free_d       = free_q + CountW'(1);
          res_status_d = ST_OK;
          res_free_d   = free_q + CountW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= CapIdx;
      untouched_q <= '0;
      free_q      <= FreeRst;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      untouched_q <= untouched_d;
      free_q      <= free_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    prod_q       <= prod_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    neg_q        <= neg_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_free_q   <= res_free_d;
  end

  fbpa_ram #(
    .Width (IW),
    .Depth (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (head_q),
    .raddr_i (head_q[AW-1:0]),
    .rdata_o (link_rdata)
  );

  fbpa_ram #(
    .Width (1),
    .Depth (CAPACITY)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (quo_q[AW-1:0]),
    .rdata_o (flag_rdata)
  );

  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = res_valid_q;
  assign status_o        = res_status_q;
  assign blk_addr_o      = res_addr_q;
  assign free_blocks_o   = res_free_q;

  a_addr_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_OK)) |-> (blk_addr_o == '0))
    else $error("block address set on a failed transaction");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("accepted transaction neither in work nor answered");

  a_result_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("work finished without a result");

  a_lists_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= CapIdx) && (untouched_q <= CapIdx))
    else $error("free list head or untouched counter beyond capacity");

endmodule
